>>> design/ple_pkg.sv
`default_nettype none

package ple_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Widest cell index and entry count over the supported depth range
	localparam int POS_MAX_W = 10;
	localparam int CNT_MAX_W = 11;

	// Request modes
	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_DELETE = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_FIND   = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	// Result status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_BADPOS   = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_EMPTY    = 3'd4;

	// Operation broadcast along the cell row
	typedef enum logic [2:0] {
		CELL_NOP  = 3'd0,
		CELL_INS  = 3'd1,
		CELL_DEL  = 3'd2,
		CELL_REM  = 3'd3,
		CELL_READ = 3'd4
	} cell_op_t;

	typedef struct packed {
		logic                 cap;
		cell_op_t             op;
		logic [POS_MAX_W-1:0] pos;
		logic [CNT_MAX_W-1:0] count;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]          mode;
		logic [4:0]          position;
		logic signed [31:0]  value;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic signed [31:0]  data_out;
		logic [3:0]          found_position;
		logic [4:0]          length;
	} rsp_t;

endpackage

`default_nettype wire

>>> design/ple_cell.sv
`default_nettype none

module ple_cell import ple_pkg::*; #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire                   clk,
	input  cell_ctl_t             ctl,
	input  wire  [DATA_WIDTH-1:0] value,
	input  wire  [DATA_WIDTH-1:0] left_data,
	input  wire  [DATA_WIDTH-1:0] right_data,
	input  wire                   seen_in,
	output logic                  seen_out,
	output logic [DATA_WIDTH-1:0] entry,
	output logic                  first,
	output logic [DATA_WIDTH-1:0] taken
);

	localparam logic [POS_MAX_W-1:0] IDX_P = POS_MAX_W'(IDX);
	localparam logic [CNT_MAX_W-1:0] IDX_C = CNT_MAX_W'(IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  hit_q;
	logic                  hit;
	logic                  at_pos;
	logic                  after_pos;
	logic                  sel;

	// Qualify the stored match with occupancy and pass the seen flag on
	assign hit       = hit_q & (IDX_C < ctl.count);
	assign seen_out  = seen_in | hit;
	assign first     = hit & ~seen_in;
	assign at_pos    = (IDX_P == ctl.pos);
	assign after_pos = (IDX_P > ctl.pos);
	assign entry     = entry_q;

	// Pick the entry that leaves the list or is read
	always_comb begin
		case (ctl.op)
			CELL_DEL:  sel = at_pos;
			CELL_READ: sel = at_pos;
			CELL_REM:  sel = first;
			default:   sel = 1'b0;
		endcase
	end

	assign taken = sel ? entry_q : '0;

	// Compare on accept, shift or load while the request executes
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			hit_q <= (entry_q == value);
		end
		case (ctl.op)
			CELL_INS: begin
				if (after_pos) begin
					entry_q <= left_data;
				end else if (at_pos) begin
					entry_q <= value;
				end
			end
			CELL_DEL: begin
				if (at_pos || after_pos) begin
					entry_q <= right_data;
				end
			end
			CELL_REM: begin
				if (seen_out) begin
					entry_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/positional_list_engine.sv
`default_nettype none

// Ordered list of up to DEPTH words held in a row of cells, one entry per cell.
// Request channel: cmd (mode, position, value) is taken at a rising edge where
// start is high and busy is low. Result channel: rsp (status, data_out,
// found_position, length) is valid for exactly one cycle while done is high;
// the receiver cannot hold results off. Every result is registered; rsp keeps it
// until the next request executes, but done flags it as valid only once.
// The accepting edge latches the request and lets every cell compare its entry
// with the value; in the following cycle the first-match flag ripples along
// the cell row, the row shifts or loads in one step, and the result and done
// are registered. busy is high in the execute cycle, so no new request is
// taken until the current one has executed.
// Reset clears the entry count, the state and done; entry contents are left
// as they are and are never read before being written.
// Every request returns exactly one result, including unused modes, which
// change nothing and report ok.
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	output logic  busy,
	input  req_t  cmd,
	output logic  done,
	output rsp_t  rsp
);

	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                state_q;
	logic   [CW-1:0]       count_q;
	req_t                  req_s1;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] in_word;
	logic [DATA_WIDTH-1:0] req_word;
	logic [DATA_WIDTH-1:0] cell_value;
	cell_ctl_t             ctl;
	cell_op_t              op;
	logic [IW-1:0]         tpos;
	logic [2:0]            status;
	logic [CW-1:0]         next_count;
	logic [DATA_WIDTH-1:0] dout;
	logic [IW-1:0]         fidx;
	logic [3:0]            fpos;
	logic                  empty;
	logic                  full;
	logic                  any_hit;
	logic [CMPW-1:0]       pos_w;
	logic [CMPW-1:0]       cnt_w;

	logic [DATA_WIDTH-1:0] ent   [DEPTH];
	logic [DATA_WIDTH-1:0] take  [DEPTH];
	logic                  first [DEPTH];
	logic                  seen  [DEPTH+1];

	assign accept   = start & ~busy;
	assign busy     = (state_q == ST_EXEC);
	assign in_word  = DATA_WIDTH'($unsigned(cmd.value));
	assign req_word = DATA_WIDTH'($unsigned(req_s1.value));

	// Compare against the new value on accept, load the latched one on insert
	assign cell_value = busy ? req_word : in_word;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign pos_w = CMPW'(req_s1.position);
	assign cnt_w = CMPW'(count_q);

	// Cell row
	assign seen[0] = 1'b0;
	assign any_hit = seen[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_lo
			assign left_d = '0;
		end else begin : g_lo
			assign left_d = ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi
			assign right_d = '0;
		end else begin : g_hi
			assign right_d = ent[i+1];
		end

		ple_cell #(
			.IDX        (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (cell_value),
			.left_data  (left_d),
			.right_data (right_d),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.entry      (ent[i]),
			.first      (first[i]),
			.taken      (take[i])
		);
	end

	// Gather the leaving entry and the first match position
	always_comb begin
		dout = '0;
		fidx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			dout = dout | take[i];
			if (first[i]) begin
				fidx = fidx | IW'(i);
			end
		end
	end

	// Decide the request outcome and the row operation
	always_comb begin
		op         = CELL_NOP;
		tpos       = IW'(req_s1.position);
		status     = STAT_OK;
		next_count = count_q;
		fpos       = '0;
		case (req_s1.mode)
			MODE_INSERT: begin
				if (full) begin
					status = STAT_FULL;
				end else if (!empty && (pos_w > cnt_w)) begin
					status = STAT_BADPOS;
				end else begin
					op         = CELL_INS;
					tpos       = empty ? '0 : IW'(req_s1.position);
					next_count = count_q + CW'(1);
				end
			end
			MODE_DELETE, MODE_READ: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status = STAT_BADPOS;
				end else if (req_s1.mode == MODE_DELETE) begin
					op         = CELL_DEL;
					next_count = count_q - CW'(1);
				end else begin
					op = CELL_READ;
				end
			end
			MODE_REMOVE, MODE_FIND: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else begin
					if (req_s1.mode == MODE_REMOVE) begin
						op = CELL_REM;
					end
					if (!any_hit) begin
						status = STAT_NOTFOUND;
					end else begin
						fpos = 4'(fidx);
						if (req_s1.mode == MODE_REMOVE) begin
							next_count = count_q - CW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Broadcast to the row; shifts only happen in the execute cycle
	always_comb begin
		ctl.cap   = accept;
		ctl.op    = busy ? op : CELL_NOP;
		ctl.pos   = POS_MAX_W'(tpos);
		ctl.count = CNT_MAX_W'(count_q);
	end

	// Hold the request for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= cmd;
		end
	end

	// Sequencer, count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					count_q <= next_count;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (busy) begin
			rsp_q.status         <= status;
			rsp_q.data_out       <= 32'(dout);
			rsp_q.found_position <= fpos;
			rsp_q.length         <= 5'(next_count);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// One result for every execute cycle, and only then
	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == $past(state_q == ST_EXEC))
		else $error("result strobe out of step with execute cycle");

	// Count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// Count moves only in the execute cycle
	a_count_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC) |=> $stable(count_q))
		else $error("entry count changed outside execute cycle");

	// Failed requests return no data
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rsp_q.status != STAT_OK)) |-> (rsp_q.data_out == '0))
		else $error("failed request returned data");

endmodule

`default_nettype wire

>>> verif/positional_list_engine_test.sv
`default_nettype none

module positional_list_engine_test;
	import ple_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LIST_DEPTH     = DEPTH_DEF;
	localparam int          RANDOM_ITEMS   = 1030;
	localparam int          CALM_TAIL      = 150;
	localparam int          DRAIN_CYCLES   = 8;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam logic [2:0]  MODE_SPARE     = MODE_READ + 3'd1;

	// Expected-result store and list predictor
	class list_scoreboard;
		logic [31:0] words[$];
		rsp_t        awaited[$];
		int          errors;

		function int count();
			return words.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Apply one accepted item to the predicted list and queue its result
		function void note(req_t r);
			rsp_t e;
			int   pos;
			int   hit;
			e   = '0;
			pos = r.position;
			hit = -1;
			if (r.mode >= MODE_DELETE && r.mode <= MODE_READ && words.size() == 0) begin
				e.status = STAT_EMPTY;
			end else begin
				case (r.mode)
					MODE_INSERT: begin
						if (words.size() >= LIST_DEPTH) begin
							e.status = STAT_FULL;
						end else if (words.size() != 0 && pos > words.size()) begin
							e.status = STAT_BADPOS;
						end else begin
							if (words.size() == 0)
								pos = 0;
							words.insert(pos, r.value);
						end
					end
					MODE_DELETE, MODE_READ: begin
						if (pos >= words.size()) begin
							e.status = STAT_BADPOS;
						end else begin
							e.data_out = words[pos];
							if (r.mode == MODE_DELETE)
								words.delete(pos);
						end
					end
					MODE_REMOVE, MODE_FIND: begin
						foreach (words[k])
							if (hit < 0 && words[k] == r.value)
								hit = k;
						if (hit < 0) begin
							e.status = STAT_NOTFOUND;
						end else begin
							e.found_position = 4'(hit);
							if (r.mode == MODE_REMOVE) begin
								e.data_out = words[hit];
								words.delete(hit);
							end
						end
					end
					default: ;
				endcase
			end
			e.length = 5'(words.size());
			awaited.push_back(e);
		endfunction

		// Compare one result with the oldest expectation
		task check(rsp_t got);
			rsp_t e;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				e = awaited.pop_front();
				if (got.status !== e.status)
					report($sformatf("status %0d, expected %0d", got.status, e.status));
				if (got.data_out !== e.data_out)
					report($sformatf("data_out %h, expected %h", got.data_out, e.data_out));
				if (got.found_position !== e.found_position)
					report($sformatf("found_position %0d, expected %0d",
						got.found_position, e.found_position));
				if (got.length !== e.length)
					report($sformatf("length %0d, expected %0d", got.length, e.length));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t cmd;
	rsp_t rsp;
	int   quiet = 0;

	list_scoreboard board = new();

	positional_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check every strobed result
	always @(posedge clk) begin
		if (arst_n && done)
			board.check(rsp);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
			$display("positional_list_engine_test NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function req_t mk(logic [2:0] m, int p, logic [31:0] v);
		req_t r;
		r.mode     = m;
		r.position = 5'(p);
		r.value    = v;
		return r;
	endfunction

	// Present an item from a falling edge and hold it until taken
	task send(req_t r);
		start <= 1'b1;
		cmd   <= r;
		do
			@(posedge clk);
		while (busy);
		board.note(r);
		@(negedge clk);
	endtask

	task pause(int n);
		start <= 1'b0;
		cmd   <= mk(3'($urandom_range(7)), $urandom_range(31), $urandom);
		repeat (n) @(negedge clk);
	endtask

	function logic [31:0] corner_word();
		case ($urandom_range(4))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// Draw a request biased by phase: fill, drain or mixed
	function req_t next_req(int phase);
		int          n;
		int          roll;
		int          t_ins, t_del, t_rem, t_fnd, t_rd;
		logic [2:0]  m;
		int          p;
		logic [31:0] v;
		n    = board.count();
		roll = $urandom_range(99);
		case (phase)
			0:       begin t_ins = 70; t_del = 78; t_rem = 84; t_fnd = 90; t_rd = 97; end
			1:       begin t_ins = 20; t_del = 50; t_rem = 70; t_fnd = 82; t_rd = 97; end
			default: begin t_ins = 30; t_del = 45; t_rem = 60; t_fnd = 75; t_rd = 97; end
		endcase
		if (roll < t_ins)      m = MODE_INSERT;
		else if (roll < t_del) m = MODE_DELETE;
		else if (roll < t_rem) m = MODE_REMOVE;
		else if (roll < t_fnd) m = MODE_FIND;
		else if (roll < t_rd)  m = MODE_READ;
		else                   m = MODE_READ + 3'($urandom_range(1, 3));

		// Mostly legal positions, now and then the edge or anything at all
		case ($urandom_range(9))
			0:       p = $urandom_range(31);
			1:       p = (m == MODE_INSERT) ? n + 1 : n;
			default: p = (m == MODE_INSERT || n == 0) ? $urandom_range(n) : $urandom_range(n - 1);
		endcase

		// Prefer words already held so that finds and removes hit
		case ($urandom_range(3))
			0, 1:    v = (n > 0) ? board.words[$urandom_range(n - 1)] : corner_word();
			2:       v = corner_word();
			default: v = $urandom;
		endcase
		return mk(m, p, v);
	endfunction

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Requests on an empty list, unused modes included
		send(mk(MODE_DELETE, 0, 32'h0));
		send(mk(MODE_REMOVE, 0, 32'h0));
		send(mk(MODE_FIND, 0, 32'h0));
		send(mk(MODE_READ, 0, 32'h0));
		send(mk(MODE_SPARE, 31, 32'hffff_ffff));
		send(mk(MODE_SPARE + 3'd1, 0, 32'h0));
		send(mk(MODE_SPARE + 3'd2, 16, 32'h5555_5555));
		// Any position goes into an empty list
		send(mk(MODE_INSERT, 16, 32'h8000_0000));
		send(mk(MODE_INSERT, 1, 32'h7fff_ffff));
		send(mk(MODE_INSERT, 3, 32'h1234_5678));
		send(mk(MODE_INSERT, 0, 32'h0));
		send(mk(MODE_FIND, 0, 32'h7fff_ffff));
		send(mk(MODE_FIND, 0, 32'h0000_3039));
		send(mk(MODE_READ, 3, 32'h0));
		send(mk(MODE_READ, 31, 32'h0));
		send(mk(MODE_READ, 2, 32'h0));
		send(mk(MODE_REMOVE, 0, 32'h8000_0000));
		send(mk(MODE_REMOVE, 0, 32'haaaa_aaaa));
		send(mk(MODE_DELETE, 2, 32'h0));
		send(mk(MODE_DELETE, 1, 32'h0));
		send(mk(MODE_DELETE, 0, 32'h0));

		// Random traffic in fill, drain and mixed phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < RANDOM_ITEMS - CALM_TAIL && (i % 200) < 160 && $urandom_range(3) == 0)
				pause($urandom_range(1, 16));
			send(next_req((i / 64) % 3));
		end
		start <= 1'b0;

		// Drain outstanding results
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("positional_list_engine_test OK");
		else
			$display("positional_list_engine_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
